// ----- rtl/http_media_range_parser_top_assert.svh -----
// Assertion macros for the media range parser checker.
// Used by hmrp_checker.sv; expects i_clk and i_rst_n in scope.
`ifndef HTTP_MEDIA_RANGE_PARSER_TOP_ASSERT_SVH
`define HTTP_MEDIA_RANGE_PARSER_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define HMRP_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define HMRP_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/hmrp_pkg.sv -----
// Shared constants and types of the media range parser.
// No dependencies; imported by every module of the block.
package hmrp_pkg;

    localparam int MAX_TEXT    = 4096;
    localparam int OFF_W       = $clog2(MAX_TEXT) + 1;
    localparam int POS_W       = 12;
    localparam int PARAM_SLOTS = 4;
    localparam int SLOT_W      = 2;
    localparam int QUAL_W      = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [QUAL_W-1:0] QUAL_ONE = QUAL_W'(1000);

    localparam logic [1:0] KIND_RANGE = 2'd0;
    localparam logic [1:0] KIND_PARAM = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR   = 3'd1;
    localparam logic [2:0] ERR_BAD_QUAL   = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd3;
    localparam logic [2:0] ERR_UNEXP_END  = 3'd4;

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] len;
    } t_span;

    typedef struct packed {
        logic              has_par;
        logic              has_rng;
        logic              has_err;
        logic              has_end;
        logic [2:0]        err_code;
        logic [POS_W-1:0]  at;
        t_span             type_span;
        t_span             sub_span;
        t_span             name_span;
        t_span             val_span;
        logic [QUAL_W-1:0] quality;
        logic [SLOT_W-1:0] slot;
    } t_bundle;

    typedef struct packed {
        logic [1:0]        kind;
        logic [POS_W-1:0]  first_start;
        logic [POS_W-1:0]  first_length;
        logic [POS_W-1:0]  second_start;
        logic [POS_W-1:0]  second_length;
        logic [QUAL_W-1:0] quality;
        logic [SLOT_W-1:0] slot;
        logic [2:0]        err_code;
        logic              last;
    } t_record;

endpackage

// ----- rtl/http_media_range_parser_top.sv -----
// Top level of the HTTP Accept media range parser.
// Instantiates hmrp_front, hmrp_queue and hmrp_back; uses hmrp_pkg.
//
// Header bytes enter through a queue-like port: a word is taken at a rising
// edge with push high and full low. A word with i_end_of_text high closes
// the header; its byte is ignored. Records leave through a second queue-like
// port: while empty is low the oldest record is on the o_ fields, and it is
// taken at an edge with pop high. Each header byte gives zero to three
// records, and o_last_of_run marks the last record of a byte.
// One byte is accepted every cycle while full is low. The output register hands
// out one record per cycle while pop is high, so a byte with two or three records
// holds the back end while a four-word queue absorbs the front end's output.
// The records of a byte are written to the queue at the edge that accepts the
// byte and are then loaded into the output register one at a time.
// While pop stays low the current record holds, the queue fills and full
// rises, which stalls the input side. Reset clears the parser state, the
// queue and the valid flag of the output register; no records are pending afterwards.
module http_media_range_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_record_kind,
    output logic [11:0] o_first_start,
    output logic [11:0] o_first_length,
    output logic [11:0] o_second_start,
    output logic [11:0] o_second_length,
    output logic [9:0]  o_quality_milli,
    output logic [1:0]  o_slot_index,
    output logic [2:0]  o_error_code,
    output logic        o_last_of_run
);
    import hmrp_pkg::*;

    logic    front_wr;
    t_bundle front_bundle;
    logic    q_full;
    logic    q_valid;
    t_bundle q_head;
    logic    head_pop;
    t_record rec;

    hmrp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_full        (q_full),
        .o_wr          (front_wr),
        .o_bundle      (front_bundle)
    );

    hmrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_data  (front_bundle),
        .i_rd    (head_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    hmrp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_head_pop   (head_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_record     (rec)
    );

    assign full            = q_full;
    assign o_record_kind   = rec.kind;
    assign o_first_start   = rec.first_start;
    assign o_first_length  = rec.first_length;
    assign o_second_start  = rec.second_start;
    assign o_second_length = rec.second_length;
    assign o_quality_milli = rec.quality;
    assign o_slot_index    = rec.slot;
    assign o_error_code    = rec.err_code;
    assign o_last_of_run   = rec.last;

endmodule

// ----- rtl/hmrp_front.sv -----
// Front end: accepts header bytes, runs the media range grammar and
// collects all records caused by one byte into one queue word. Uses hmrp_pkg.
module hmrp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [7:0]       i_text_byte,
    input  logic             i_end_of_text,
    input  logic             i_full,
    output logic             o_wr,
    output hmrp_pkg::t_bundle o_bundle
);
    import hmrp_pkg::*;

    typedef enum logic [12:0] {
        PH_TYPE_WAIT  = 13'd1,
        PH_TYPE       = 13'd2,
        PH_SUB_START  = 13'd4,
        PH_SUB        = 13'd8,
        PH_AFTER      = 13'd16,
        PH_PNAME_WAIT = 13'd32,
        PH_PNAME      = 13'd64,
        PH_VSTART     = 13'd128,
        PH_VTOKEN     = 13'd256,
        PH_QUOTED     = 13'd512,
        PH_QFIRST     = 13'd1024,
        PH_QINT       = 13'd2048,
        PH_QFRAC      = 13'd4096
    } t_phase;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_EQ      = 8'h3d;
    localparam logic [7:0] CH_UPPER_Q = 8'h51;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_LOWER_Q = 8'h71;

    function automatic logic in_rng(input logic [7:0] c, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic is_hws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return in_rng(c, CH_ZERO, CH_NINE);
    endfunction

    function automatic logic is_tchar(input logic [7:0] c);
        return in_rng(c, 8'h41, 8'h5a) || in_rng(c, 8'h5e, 8'h7a) || is_digit(c) ||
               (c == 8'h21) || in_rng(c, 8'h23, 8'h27) || in_rng(c, 8'h2a, 8'h2b) ||
               in_rng(c, 8'h2d, 8'h2e) || (c == 8'h7c) || (c == 8'h7e);
    endfunction

    function automatic logic is_qdtext(input logic [7:0] c);
        return is_hws(c) || (c == 8'h21) || in_rng(c, 8'h23, 8'h5b) ||
               in_rng(c, 8'h5d, 8'h7e) || in_rng(c, 8'h80, 8'hff);
    endfunction

    function automatic logic is_escapable(input logic [7:0] c);
        return is_hws(c) || in_rng(c, 8'h21, 8'h7e) || in_rng(c, 8'h80, 8'hff);
    endfunction

    t_phase            r_phase, n_phase;
    logic [OFF_W-1:0]  r_offset, n_offset;
    t_span             r_type, n_type;
    t_span             r_sub, n_sub;
    t_span             r_name, n_name;
    t_span             r_val, n_val;
    logic [QUAL_W-1:0] r_qacc, n_qacc;
    logic [1:0]        r_fdl, n_fdl;
    logic              r_name_q, n_name_q;
    logic              r_esc, n_esc;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_err_hold, n_err_hold;

    logic              accept;
    logic [7:0]        c;
    logic              e;
    logic              fail;
    logic [2:0]        fail_code;
    logic              emit_par;
    logic              emit_rng;
    logic              do_after;
    logic [3:0]        digit;
    logic [6:0]        weight;
    logic [QUAL_W-1:0] frac_add;
    logic [POS_W-1:0]  pos;
    logic [SLOT_W-1:0] slot_inc;

    assign accept   = i_push && !i_full;
    assign c        = i_text_byte;
    assign e        = i_end_of_text;
    assign digit    = c[3:0];
    assign pos      = r_offset[POS_W-1:0];
    assign frac_add = QUAL_W'(digit) * QUAL_W'(weight);
    assign slot_inc = (r_slot == SLOT_W'(PARAM_SLOTS - 1)) ? '0 : r_slot + 1'b1;

    always_comb begin
        case (r_fdl)
            2'd3:    weight = 7'd100;
            2'd2:    weight = 7'd10;
            default: weight = 7'd1;
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_offset   = r_offset;
        n_type     = r_type;
        n_sub      = r_sub;
        n_name     = r_name;
        n_val      = r_val;
        n_qacc     = r_qacc;
        n_fdl      = r_fdl;
        n_name_q   = r_name_q;
        n_esc      = r_esc;
        n_slot     = r_slot;
        n_err_hold = r_err_hold;
        fail       = 1'b0;
        fail_code  = ERR_NONE;
        emit_par   = 1'b0;
        emit_rng   = 1'b0;
        do_after   = 1'b0;

        if (!r_err_hold) begin
            if (!e && (r_offset >= OFF_W'(MAX_TEXT))) begin
                fail      = 1'b1;
                fail_code = ERR_TOO_LONG;
            end else begin
                case (r_phase)
                    PH_TYPE_WAIT: begin
                        if (!(e || is_hws(c) || (c == CH_COMMA))) begin
                            if (is_tchar(c)) begin
                                n_type.start = pos;
                                n_type.len   = POS_W'(1);
                                n_qacc       = QUAL_ONE;
                                n_slot       = '0;
                                n_phase      = PH_TYPE;
                            end else begin
                                fail      = 1'b1;
                                fail_code = ERR_BAD_CHAR;
                            end
                        end
                    end
                    PH_TYPE: begin
                        if (e) begin
                            fail      = 1'b1;
                            fail_code = ERR_UNEXP_END;
                        end else if (is_tchar(c)) begin
                            n_type.len = r_type.len + 1'b1;
                        end else if (c == CH_SLASH) begin
                            n_phase = PH_SUB_START;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ERR_BAD_CHAR;
                        end
                    end
                    PH_SUB_START: begin
                        if (e) begin
                            fail      = 1'b1;
                            fail_code = ERR_UNEXP_END;
                        end else if (is_tchar(c)) begin
                            n_sub.start = pos;
                            n_sub.len   = POS_W'(1);
                            n_phase     = PH_SUB;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ERR_BAD_CHAR;
                        end
                    end
                    PH_SUB: begin
                        if (!e && is_tchar(c)) begin
                            n_sub.len = r_sub.len + 1'b1;
                        end else begin
                            do_after = 1'b1;
                        end
                    end
                    PH_AFTER: begin
                        do_after = 1'b1;
                    end
                    PH_PNAME_WAIT: begin
                        if (e) begin
                            fail      = 1'b1;
                            fail_code = ERR_UNEXP_END;
                        end else if (is_hws(c)) begin
                            n_phase = r_phase;
                        end else if (is_tchar(c)) begin
                            n_name.start = pos;
                            n_name.len   = POS_W'(1);
                            n_name_q     = (c == CH_LOWER_Q) || (c == CH_UPPER_Q);
                            n_phase      = PH_PNAME;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ERR_BAD_CHAR;
                        end
                    end
                    PH_PNAME: begin
                        if (e) begin
                            fail      = 1'b1;
                            fail_code = ERR_UNEXP_END;
                        end else if (is_tchar(c)) begin
                            n_name.len = r_name.len + 1'b1;
                            n_name_q   = 1'b0;
                        end else if (c == CH_EQ) begin
                            n_phase = r_name_q ? PH_QFIRST : PH_VSTART;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ERR_BAD_CHAR;
                        end
                    end
                    PH_VSTART: begin
                        if (e) begin
                            fail      = 1'b1;
                            fail_code = ERR_UNEXP_END;
                        end else if (c == CH_DQUOTE) begin
                            n_val.start = pos + 1'b1;
                            n_val.len   = '0;
                            n_esc       = 1'b0;
                            n_phase     = PH_QUOTED;
                        end else if (is_tchar(c)) begin
                            n_val.start = pos;
                            n_val.len   = POS_W'(1);
                            n_phase     = PH_VTOKEN;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ERR_BAD_CHAR;
                        end
                    end
                    PH_VTOKEN: begin
                        if (!e && is_tchar(c)) begin
                            n_val.len = r_val.len + 1'b1;
                        end else begin
                            emit_par = 1'b1;
                            n_slot   = slot_inc;
                            do_after = 1'b1;
                        end
                    end
                    PH_QUOTED: begin
                        if (e) begin
                            fail      = 1'b1;
                            fail_code = ERR_UNEXP_END;
                        end else if (r_esc) begin
                            if (is_escapable(c)) begin
                                n_val.len = r_val.len + 1'b1;
                                n_esc     = 1'b0;
                            end else begin
                                fail      = 1'b1;
                                fail_code = ERR_BAD_CHAR;
                            end
                        end else if (c == CH_BSLASH) begin
                            n_val.len = r_val.len + 1'b1;
                            n_esc     = 1'b1;
                        end else if (c == CH_DQUOTE) begin
                            emit_par = 1'b1;
                            n_slot   = slot_inc;
                            n_phase  = PH_AFTER;
                        end else if (is_qdtext(c)) begin
                            n_val.len = r_val.len + 1'b1;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ERR_BAD_CHAR;
                        end
                    end
                    PH_QFIRST: begin
                        if (e) begin
                            fail      = 1'b1;
                            fail_code = ERR_UNEXP_END;
                        end else if (c == CH_ZERO) begin
                            n_qacc  = '0;
                            n_phase = PH_QINT;
                        end else if (c == CH_ONE) begin
                            n_qacc  = QUAL_ONE;
                            n_phase = PH_QINT;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ERR_BAD_QUAL;
                        end
                    end
                    PH_QINT: begin
                        if (!e && (c == CH_DOT)) begin
                            n_fdl   = 2'd3;
                            n_phase = PH_QFRAC;
                        end else begin
                            do_after = 1'b1;
                        end
                    end
                    PH_QFRAC: begin
                        if (!e && is_digit(c) && (r_fdl != 2'd0)) begin
                            if ((r_qacc == QUAL_ONE) && (digit != 4'd0)) begin
                                fail      = 1'b1;
                                fail_code = ERR_BAD_QUAL;
                            end else begin
                                if (r_qacc != QUAL_ONE) begin
                                    n_qacc = r_qacc + frac_add;
                                end
                                n_fdl = r_fdl - 1'b1;
                            end
                        end else begin
                            do_after = 1'b1;
                        end
                    end
                    default: begin
                        fail      = 1'b1;
                        fail_code = ERR_BAD_CHAR;
                    end
                endcase

                if (do_after) begin
                    if (e || (c == CH_COMMA)) begin
                        emit_rng = 1'b1;
                        n_phase  = PH_TYPE_WAIT;
                    end else if (is_hws(c)) begin
                        n_phase = PH_AFTER;
                    end else if (c == CH_SEMI) begin
                        n_phase = PH_PNAME_WAIT;
                    end else begin
                        fail      = 1'b1;
                        fail_code = ERR_BAD_CHAR;
                    end
                end
            end
        end

        if (fail) begin
            n_err_hold = 1'b1;
        end

        if (e) begin
            n_phase    = PH_TYPE_WAIT;
            n_offset   = '0;
            n_qacc     = QUAL_ONE;
            n_fdl      = 2'd3;
            n_name_q   = 1'b0;
            n_esc      = 1'b0;
            n_slot     = '0;
            n_err_hold = 1'b0;
        end else if (r_offset < OFF_W'(MAX_TEXT)) begin
            n_offset = r_offset + 1'b1;
        end
    end

    always_comb begin
        o_bundle.has_par   = emit_par;
        o_bundle.has_rng   = emit_rng;
        o_bundle.has_err   = fail;
        o_bundle.has_end   = e;
        o_bundle.err_code  = fail_code;
        o_bundle.at        = pos;
        o_bundle.type_span = r_type;
        o_bundle.sub_span  = r_sub;
        o_bundle.name_span = r_name;
        o_bundle.val_span  = r_val;
        o_bundle.quality   = r_qacc;
        o_bundle.slot      = r_slot;
    end

    assign o_wr = accept && (emit_par || emit_rng || fail || e);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TYPE_WAIT;
            r_offset   <= '0;
            r_qacc     <= QUAL_ONE;
            r_fdl      <= 2'd3;
            r_name_q   <= 1'b0;
            r_esc      <= 1'b0;
            r_slot     <= '0;
            r_err_hold <= 1'b0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_offset   <= n_offset;
            r_qacc     <= n_qacc;
            r_fdl      <= n_fdl;
            r_name_q   <= n_name_q;
            r_esc      <= n_esc;
            r_slot     <= n_slot;
            r_err_hold <= n_err_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type <= n_type;
            r_sub  <= n_sub;
            r_name <= n_name;
            r_val  <= n_val;
        end
    end

endmodule

// ----- rtl/hmrp_queue.sv -----
// Short queue of record bundles between the parser front and the record back.
// Uses hmrp_pkg for the bundle type and the depth.
module hmrp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  hmrp_pkg::t_bundle i_data,
    input  logic              i_rd,
    output logic              o_full,
    output logic              o_valid,
    output hmrp_pkg::t_bundle o_data
);
    import hmrp_pkg::*;

    t_bundle           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              do_wr;
    logic              do_rd;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/hmrp_back.sv -----
// Back end: walks the records of the queue head in order and holds each
// in the output register until it is popped. Uses hmrp_pkg.
module hmrp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  hmrp_pkg::t_bundle i_head,
    output logic              o_head_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output hmrp_pkg::t_record o_record
);
    import hmrp_pkg::*;

    logic [3:0] r_sent;
    logic       r_valid;
    t_record    r_rec;
    logic [3:0] remaining;
    logic [3:0] pick;
    t_record    rec;
    logic       load;

    assign remaining = {i_head.has_end, i_head.has_err, i_head.has_rng, i_head.has_par}
                       & ~r_sent;
    assign load      = i_head_valid && (!r_valid || i_pop);

    always_comb begin
        pick = '0;
        rec  = '0;
        if (remaining[0]) begin
            pick              = 4'b0001;
            rec.kind          = KIND_PARAM;
            rec.first_start   = i_head.name_span.start;
            rec.first_length  = i_head.name_span.len;
            rec.second_start  = i_head.val_span.start;
            rec.second_length = i_head.val_span.len;
            rec.slot          = i_head.slot;
        end else if (remaining[1]) begin
            pick              = 4'b0010;
            rec.kind          = KIND_RANGE;
            rec.first_start   = i_head.type_span.start;
            rec.first_length  = i_head.type_span.len;
            rec.second_start  = i_head.sub_span.start;
            rec.second_length = i_head.sub_span.len;
            rec.quality       = i_head.quality;
        end else if (remaining[2]) begin
            pick            = 4'b0100;
            rec.kind        = KIND_ERROR;
            rec.first_start = i_head.at;
            rec.err_code    = i_head.err_code;
        end else begin
            pick            = 4'b1000;
            rec.kind        = KIND_END;
            rec.first_start = i_head.at;
        end
        rec.last = ((remaining & ~pick) == 4'b0000);
    end

    assign o_head_pop = load && rec.last;
    assign o_empty    = !r_valid;
    assign o_record   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sent  <= rec.last ? 4'b0000 : (r_sent | pick);
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= rec;
        end
    end

endmodule

// ----- rtl/hmrp_checker.sv -----
// Port-level checks of the media range parser, bound to the top level.
// Uses hmrp_pkg and http_media_range_parser_top_assert.svh.
`include "http_media_range_parser_top_assert.svh"

module hmrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  i_text_byte,
    input logic        i_end_of_text,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_record_kind,
    input logic [11:0] o_first_start,
    input logic [11:0] o_first_length,
    input logic [11:0] o_second_start,
    input logic [11:0] o_second_length,
    input logic [9:0]  o_quality_milli,
    input logic [1:0]  o_slot_index,
    input logic [2:0]  o_error_code,
    input logic        o_last_of_run
);
    import hmrp_pkg::*;

    `HMRP_ASSERT_ANY(a_reset_empties, !i_rst_n |=> empty, "no record may follow reset")
    `HMRP_ASSERT_RUN(a_stall_holds, !empty && !pop |=> !empty && $stable(o_record_kind) && $stable(o_first_start) && $stable(o_last_of_run), "stalled word changed")
    `HMRP_ASSERT_RUN(a_quality_range, !empty |-> o_quality_milli <= QUAL_ONE, "quality above one")
    `HMRP_ASSERT_RUN(a_quality_kind, !empty && o_record_kind != KIND_RANGE |-> o_quality_milli == '0, "quality on a record other than a range")
    `HMRP_ASSERT_RUN(a_error_code_kind, !empty |-> ((o_record_kind == KIND_ERROR) == (o_error_code != ERR_NONE)), "error code does not match kind")

endmodule

bind http_media_range_parser_top hmrp_checker u_checker (.*);
